@@ hw/rtl/ltrr_pkg.sv @@
// Shared types and codes for the load tiered round robin selector.
`timescale 1ns / 1ps
package ltrr_pkg;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_UPDATE = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_SELECT = 2'd3;

  localparam logic [1:0] CLS_HEALTHY  = 2'd0;
  localparam logic [1:0] CLS_MODERATE = 2'd1;
  localparam logic [1:0] CLS_BUSY     = 2'd2;
  localparam logic [1:0] CLS_UNUSABLE = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_LOOKUP = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  localparam logic REG_HEALTHY  = 1'b0;
  localparam logic REG_MODERATE = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIND,
    S_EXEC,
    S_MOD,
    S_PICK,
    S_RESULT
  } state_t;

  // command broadcast to every cell
  typedef struct packed {
    logic       wr_new;
    logic       set;
    logic       clr;
    logic       drop;
    logic       pick;
    logic [1:0] cls;
    logic [1:0] new_cls;
  } cell_cmd_t;

endpackage

@@ hw/rtl/ltrr_cell.sv @@
// One table slot: id, class and list rank, with chained lookup outputs.
`timescale 1ns / 1ps
module ltrr_cell #(
  parameter int ID_W = 16,
  parameter int RW = 6
) (
  input  logic               clk,
  input  logic               rst,
  input  ltrr_pkg::cell_cmd_t cmd,
  input  logic [ID_W-1:0]    req_id,
  input  logic [RW-1:0]      key_rank,
  input  logic [RW-1:0]      new_rank,
  input  logic               free_in,
  output logic               free_out,
  input  logic               hit_in,
  output logic               hit_out,
  input  logic [1:0]         hcls_in,
  output logic [1:0]         hcls_out,
  input  logic [RW-1:0]      hrank_in,
  output logic [RW-1:0]      hrank_out,
  input  logic [ID_W-1:0]    acc_in,
  output logic [ID_W-1:0]    acc_out
);
  import ltrr_pkg::*;

  logic            valid;
  logic [ID_W-1:0] idr;
  logic [1:0]      cls;
  logic [RW-1:0]   rank;
  logic            match;
  logic            pickm;
  logic            take;
  logic            sel;

  assign match = valid && (idr == req_id);
  assign pickm = valid && (cls == cmd.cls) && (cls != CLS_UNUSABLE) && (rank == key_rank);
  assign take = !valid && !free_in;
  assign sel = cmd.pick ? pickm : match;

  assign free_out = free_in | !valid;
  assign hit_out = hit_in | match;
  assign hcls_out = hcls_in | (match ? cls : 2'd0);
  assign hrank_out = hrank_in | (match ? rank : '0);
  assign acc_out = acc_in | (sel ? idr : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      if (cmd.wr_new && take) begin
        valid <= 1'b1;
      end
      if (cmd.clr && match) begin
        valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_new && take) begin
      idr <= req_id;
      cls <= CLS_UNUSABLE;
    end
    if (cmd.drop && valid && (cls == cmd.cls) && (rank > key_rank)) begin
      rank <= rank - 1'b1;
    end
    if (cmd.set && match) begin
      cls <= cmd.new_cls;
      rank <= new_rank;
    end
  end

endmodule

@@ hw/rtl/load_tiered_round_robin_selector_unit.sv @@
// Top level: request sequencer, class lists bookkeeping and the row of table cells.
// Add, update and remove step through the find, execute and result states.
// A select that finds a server adds a bit-serial 32-step remainder of the class
// counter by the class length before the pick; with all lists empty it skips both.
// The sequencer handles one request at a time; synchronous reset clears the table,
// list lengths and counters and sets the limits to 20 and 40. The result register lets the next
// request enter while a result waits.
`timescale 1ns / 1ps
module load_tiered_round_robin_selector_unit #(
  parameter int MAX_SERVERS = 64,
  parameter int ID_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // operation[1:0], server_id[17:2], cpu_load[25:18], memory_negative[26]
  input  logic [31:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // status_code[1:0], selected_valid[2], selected_id[18:3]
  output logic [23:0] m_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ltrr_pkg::*;

  localparam int RW = $clog2(MAX_SERVERS);
  localparam int LW = $clog2(MAX_SERVERS + 1);

  state_t state, state_next;

  logic [6:0]          healthy_limit;
  logic [6:0]          moderate_limit;
  logic [LW-1:0]       len [0:2];
  logic [31:0]         ctr [0:2];
  logic [1:0]          op_r;
  logic [ID_WIDTH-1:0] id_r;
  logic [1:0]          newc_r;
  logic                hit_r;
  logic [1:0]          hcls_r;
  logic [RW-1:0]       hrank_r;
  logic                full_r;
  logic [1:0]          sel_cls;
  logic [LW-1:0]       div;
  logic [31:0]         dvd;
  logic [LW-1:0]       rem;
  logic [4:0]          cnt;
  logic [1:0]          res_status;
  logic                res_valid;
  logic [15:0]         res_sel;
  logic [1:0]          o_status;
  logic                o_valid;
  logic [15:0]         o_sel;

  cell_cmd_t           cmd;
  logic [RW-1:0]       key_rank;
  logic [RW-1:0]       new_rank;
  logic [LW:0]         rem2;
  logic                in_beat;
  logic [1:0]          in_op;
  logic signed [7:0]   in_load;
  logic                in_mem;
  logic [1:0]          in_cls;

  logic                free_c [0:MAX_SERVERS];
  logic                hit_c [0:MAX_SERVERS];
  logic [1:0]          hcls_c [0:MAX_SERVERS];
  logic [RW-1:0]       hrank_c [0:MAX_SERVERS];
  logic [ID_WIDTH-1:0] acc_c [0:MAX_SERVERS];

  assign in_beat = s_tvalid && s_tready;
  assign s_tready = (state == S_IDLE);
  assign in_op = s_tdata[1:0];
  assign in_load = s_tdata[25:18];
  assign in_mem = s_tdata[26];

  always_comb begin
    if (in_load < 0 || in_mem) begin
      in_cls = CLS_UNUSABLE;
    end else if (in_load[6:0] < healthy_limit) begin
      in_cls = CLS_HEALTHY;
    end else if (in_load[6:0] < moderate_limit) begin
      in_cls = CLS_MODERATE;
    end else begin
      in_cls = CLS_BUSY;
    end
  end

  // config port
  assign pready = 1'b1;
  assign prdata = {25'd0, (paddr[2] == REG_MODERATE) ? moderate_limit : healthy_limit};

  always_ff @(posedge clk) begin
    if (rst) begin
      healthy_limit <= 7'd20;
      moderate_limit <= 7'd40;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_HEALTHY) begin
        healthy_limit <= pwdata[6:0];
      end else begin
        moderate_limit <= pwdata[6:0];
      end
    end
  end

  // cell row
  assign free_c[0] = 1'b0;
  assign hit_c[0] = 1'b0;
  assign hcls_c[0] = 2'd0;
  assign hrank_c[0] = '0;
  assign acc_c[0] = '0;

  for (genvar g = 0; g < MAX_SERVERS; g++) begin : g_cell
    ltrr_cell #(.ID_W(ID_WIDTH), .RW(RW)) u_cell (
      .clk(clk),
      .rst(rst),
      .cmd(cmd),
      .req_id(id_r),
      .key_rank(key_rank),
      .new_rank(new_rank),
      .free_in(free_c[g]),
      .free_out(free_c[g+1]),
      .hit_in(hit_c[g]),
      .hit_out(hit_c[g+1]),
      .hcls_in(hcls_c[g]),
      .hcls_out(hcls_c[g+1]),
      .hrank_in(hrank_c[g]),
      .hrank_out(hrank_c[g+1]),
      .acc_in(acc_c[g]),
      .acc_out(acc_c[g+1])
    );
  end

  assign rem2 = {rem, dvd[31]};

  always_comb begin
    state_next = state;
    cmd = '0;
    key_rank = hrank_r;
    new_rank = RW'(len[newc_r == CLS_UNUSABLE ? 2'd0 : newc_r]);
    unique case (state)
      S_IDLE: begin
        if (in_beat) state_next = S_FIND;
      end
      S_FIND: state_next = S_EXEC;
      S_EXEC: begin
        cmd.cls = hcls_r;
        cmd.new_cls = newc_r;
        unique case (op_r)
          OP_ADD: begin
            cmd.wr_new = !hit_r && !full_r;
            state_next = S_RESULT;
          end
          OP_UPDATE: begin
            cmd.set = hit_r && (hcls_r != newc_r);
            cmd.drop = hit_r && (hcls_r != newc_r) && (hcls_r != CLS_UNUSABLE);
            state_next = S_RESULT;
          end
          OP_REMOVE: begin
            cmd.clr = hit_r;
            cmd.drop = hit_r && (hcls_r != CLS_UNUSABLE);
            state_next = S_RESULT;
          end
          default: begin
            if (len[0] != '0 || len[1] != '0 || len[2] != '0) begin
              state_next = S_MOD;
            end else begin
              state_next = S_RESULT;
            end
          end
        endcase
      end
      S_MOD: begin
        if (cnt == 5'd31) state_next = S_PICK;
      end
      S_PICK: begin
        cmd.pick = 1'b1;
        cmd.cls = sel_cls;
        key_rank = RW'(rem);
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (!m_tvalid || m_tready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      m_tvalid <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        len[i] <= '0;
        ctr[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (state == S_RESULT && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (state == S_EXEC) begin
        for (int i = 0; i < 3; i++) begin
          if ((op_r == OP_UPDATE && hit_r && hcls_r != newc_r) ||
              (op_r == OP_REMOVE && hit_r)) begin
            if (hcls_r == 2'(i) && !(op_r == OP_UPDATE && newc_r == 2'(i))) begin
              len[i] <= len[i] - 1'b1;
            end else if (op_r == OP_UPDATE && newc_r == 2'(i)) begin
              len[i] <= len[i] + 1'b1;
            end
          end
        end
      end
      if (state == S_PICK) begin
        for (int i = 0; i < 3; i++) begin
          if (sel_cls == 2'(i)) ctr[i] <= ctr[i] + 32'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      op_r <= in_op;
      id_r <= ID_WIDTH'(s_tdata[17:2]);
      newc_r <= in_cls;
    end
    if (state == S_FIND) begin
      hit_r <= hit_c[MAX_SERVERS];
      hcls_r <= hcls_c[MAX_SERVERS];
      hrank_r <= hrank_c[MAX_SERVERS];
      full_r <= !free_c[MAX_SERVERS];
    end
    if (state == S_EXEC) begin
      res_valid <= 1'b0;
      res_sel <= 16'd0;
      unique case (op_r) inside
        OP_ADD: begin
          if (hit_r) res_status <= ST_LOOKUP;
          else if (full_r) res_status <= ST_FULL;
          else res_status <= ST_OK;
        end
        OP_UPDATE, OP_REMOVE: begin
          res_status <= hit_r ? ST_OK : ST_LOOKUP;
        end
        default: begin
          res_status <= ST_OK;
          rem <= '0;
          cnt <= 5'd0;
          if (len[0] != '0) begin
            sel_cls <= CLS_HEALTHY;
            div <= len[0];
            dvd <= ctr[0];
          end else if (len[1] != '0) begin
            sel_cls <= CLS_MODERATE;
            div <= len[1];
            dvd <= ctr[1];
          end else begin
            sel_cls <= CLS_BUSY;
            div <= len[2];
            dvd <= ctr[2];
          end
        end
      endcase
    end
    if (state == S_MOD) begin
      if (rem2 >= {1'b0, div}) rem <= LW'(rem2 - {1'b0, div});
      else rem <= rem2[LW-1:0];
      dvd <= {dvd[30:0], 1'b0};
      cnt <= cnt + 5'd1;
    end
    if (state == S_PICK) begin
      res_valid <= 1'b1;
      res_sel <= 16'(acc_c[MAX_SERVERS]);
    end
    if (state == S_RESULT && (!m_tvalid || m_tready)) begin
      o_status <= res_status;
      o_valid <= res_valid;
      o_sel <= res_sel;
    end
  end

  assign m_tdata = {5'd0, o_sel, o_valid, o_status};

  a_sel_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[2] |-> m_tdata[1:0] == ST_OK)
    else $error("selected result with nonzero status");
  a_sel_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[2] |-> m_tdata[18:3] == 16'd0)
    else $error("unselected result carries an id");
  a_len_sum: assert property (@(posedge clk) disable iff (rst)
    (32'(len[0]) + 32'(len[1]) + 32'(len[2])) <= 32'(MAX_SERVERS))
    else $error("class lists exceed table size");
  a_start: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> state == S_FIND)
    else $error("accepted beat did not start lookup");

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the load tiered round robin selector unit.
`timescale 1ns / 1ps
module testbench;
  import ltrr_pkg::*;

  localparam int SLOTS = 64;
  localparam int CYCLE_LIMIT = 1500000;

  typedef struct packed {
    logic [15:0] id;
    logic        valid;
    logic [1:0]  status;
  } reply_t;

  class selector_scoreboard;
    logic [6:0]  healthy_lim;
    logic [6:0]  moderate_lim;
    bit          used[SLOTS];
    logic [15:0] srv[SLOTS];
    logic [1:0]  tier[SLOTS];
    logic [15:0] tier_list[3][$];
    logic [31:0] rotor[3];
    reply_t      pending[$];
    int          errors, replies, picks, fulls;

    function new();
      healthy_lim = 7'd20;
      moderate_lim = 7'd40;
      foreach (used[i]) used[i] = 0;
      foreach (rotor[i]) rotor[i] = '0;
    endfunction

    function int lookup(logic [15:0] id);
      for (int i = 0; i < SLOTS; i++)
        if (used[i] && srv[i] == id) return i;
      return -1;
    endfunction

    function logic [1:0] grade(logic [7:0] load, logic mneg);
      int l;
      l = $signed(load);
      if (l < 0 || mneg) return CLS_UNUSABLE;
      if (l < int'(healthy_lim)) return CLS_HEALTHY;
      if (l < int'(moderate_lim)) return CLS_MODERATE;
      return CLS_BUSY;
    endfunction

    function void unlink(logic [1:0] c, logic [15:0] id);
      if (c == CLS_UNUSABLE) return;
      foreach (tier_list[c][i])
        if (tier_list[c][i] == id) begin
          tier_list[c].delete(i);
          return;
        end
    endfunction

    function void note_request(logic [1:0] op, logic [15:0] id, logic [7:0] load,
                               logic mneg);
      reply_t r;
      int slot;
      logic [1:0] nc;
      r = '0;
      r.status = ST_OK;
      case (op)
        OP_ADD: begin
          if (lookup(id) >= 0) r.status = ST_LOOKUP;
          else begin
            slot = -1;
            for (int i = 0; i < SLOTS; i++)
              if (!used[i]) begin
                slot = i;
                break;
              end
            if (slot < 0) r.status = ST_FULL;
            else begin
              used[slot] = 1;
              srv[slot] = id;
              tier[slot] = CLS_UNUSABLE;
            end
          end
        end
        OP_UPDATE: begin
          slot = lookup(id);
          if (slot < 0) r.status = ST_LOOKUP;
          else begin
            nc = grade(load, mneg);
            if (nc != tier[slot]) begin
              unlink(tier[slot], id);
              if (nc != CLS_UNUSABLE) tier_list[nc] = {tier_list[nc], id};
              tier[slot] = nc;
            end
          end
        end
        OP_REMOVE: begin
          slot = lookup(id);
          if (slot < 0) r.status = ST_LOOKUP;
          else begin
            unlink(tier[slot], id);
            used[slot] = 0;
          end
        end
        default: begin
          for (int c = 0; c < 3; c++)
            if (tier_list[c].size() != 0) begin
              r.id = tier_list[c][rotor[c] % tier_list[c].size()];
              rotor[c] = rotor[c] + 1;
              r.valid = 1;
              break;
            end
        end
      endcase
      pending = {pending, r};
    endfunction

    function void check_result(logic [23:0] d);
      reply_t e;
      replies++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual %h", $time, d);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (d[1:0] != e.status) begin
        $display("%0t: status expected %0d actual %0d", $time, e.status, d[1:0]);
        errors++;
      end
      if (d[2] != e.valid) begin
        $display("%0t: selected_valid expected %0d actual %0d", $time, e.valid, d[2]);
        errors++;
      end
      if (d[18:3] != e.id) begin
        $display("%0t: selected_id expected %h actual %h", $time, e.id, d[18:3]);
        errors++;
      end
      if (e.valid) picks++;
      if (e.status == ST_FULL) fulls++;
    endfunction
  endclass

  logic        clk, rst;
  logic        s_tvalid, s_tready;
  logic [31:0] s_tdata;
  logic        m_tvalid, m_tready;
  logic [23:0] m_tdata;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;

  selector_scoreboard sb;
  bit          park_rx;
  int          cycles;
  int          sent;
  logic [15:0] id_pool[90];

  load_tiered_round_robin_selector_unit u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk)
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);

  // receiver: random stalls, plus one long park on request
  initial begin
    int run;
    m_tready <= 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (park_rx) begin
        m_tready <= 0;
        for (int n = 0; n < 400; n++) @(posedge clk);
        park_rx = 0;
      end else if ($urandom_range(0, 9) < 7) begin
        m_tready <= 1;
        run = $urandom_range(1, 30);
        repeat (run) @(posedge clk);
      end else begin
        m_tready <= 0;
        run = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        repeat (run) @(posedge clk);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 95) return $urandom_range(1, 4);
    return $urandom_range(15, 60);
  endfunction

  task automatic send(logic [1:0] op, logic [15:0] id, logic [7:0] load, logic mneg,
                      int gap);
    s_tvalid <= 1;
    s_tdata <= {5'd0, mneg, load, id, op};
    do @(posedge clk); while (!s_tready);
    sb.note_request(op, id, load, mneg);
    sent++;
    if (gap > 0) begin
      s_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic reg_write(logic [2:0] addr, logic [6:0] value);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= addr;
    pwdata <= {25'd0, value};
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    if (addr == 3'd0) sb.healthy_lim = value;
    else sb.moderate_lim = value;
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (45) @(posedge clk);
  endtask

  task automatic random_item(int add_weight);
    logic [1:0]  op;
    logic [15:0] id;
    logic [7:0]  load;
    logic        mneg;
    int r;
    r = $urandom_range(0, 99);
    if (r < add_weight) op = OP_ADD;
    else if (r < add_weight + 35) op = OP_UPDATE;
    else if (r < add_weight + 48) op = OP_REMOVE;
    else op = OP_SELECT;
    id = ($urandom_range(0, 99) < 88) ? id_pool[$urandom_range(0, 89)] : 16'($urandom);
    r = $urandom_range(0, 99);
    load = (r < 10) ? 8'($urandom) : 8'($urandom_range(0, 127));
    mneg = ($urandom_range(0, 99) < 8);
    send(op, id, load, mneg, pick_gap());
  endtask

  initial begin
    logic [6:0] hl[6] = '{7'd20, 7'd0, 7'd127, 7'd60, 7'd10, 7'd0};
    logic [6:0] ml[6] = '{7'd40, 7'd0, 7'd127, 7'd30, 7'd100, 7'd127};
    sb = new();
    cycles = 0;
    sent = 0;
    park_rx = 0;
    rst <= 1;
    s_tvalid <= 0;
    s_tdata <= '0;
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    paddr <= '0;
    pwdata <= '0;
    foreach (id_pool[i]) id_pool[i] = 16'($urandom);
    id_pool[0] = 16'h0000;
    id_pool[1] = 16'hFFFF;
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: duplicates, absent ids, class moves, empty select, wrap of the rotation
    send(OP_SELECT, 16'h0000, 8'd0, 0, 0);
    send(OP_ADD, 16'h0000, 8'd0, 0, 0);
    send(OP_ADD, 16'hFFFF, 8'd0, 0, 1);
    send(OP_ADD, 16'h0000, 8'd0, 0, 0);
    send(OP_SELECT, 16'h0000, 8'd0, 0, 0);
    send(OP_UPDATE, 16'h0000, 8'd0, 0, 0);
    send(OP_UPDATE, 16'hFFFF, 8'd127, 0, 2);
    send(OP_UPDATE, 16'h1234, 8'd5, 0, 0);
    send(OP_SELECT, 16'h0000, 8'd0, 0, 0);
    send(OP_SELECT, 16'h0000, 8'd0, 0, 0);
    send(OP_UPDATE, 16'h0000, 8'd19, 0, 0);
    send(OP_UPDATE, 16'h0000, 8'h80, 0, 0);
    send(OP_SELECT, 16'h0000, 8'd0, 0, 0);
    send(OP_UPDATE, 16'hFFFF, 8'd30, 1, 0);
    send(OP_SELECT, 16'h0000, 8'd0, 0, 0);
    send(OP_UPDATE, 16'hFFFF, 8'd20, 0, 0);
    send(OP_UPDATE, 16'h0000, 8'd39, 0, 0);
    send(OP_SELECT, 16'h0000, 8'd0, 0, 0);
    send(OP_SELECT, 16'h0000, 8'd0, 0, 0);
    send(OP_REMOVE, 16'h5555, 8'd0, 0, 0);
    send(OP_REMOVE, 16'hFFFF, 8'd0, 0, 0);
    send(OP_SELECT, 16'h0000, 8'd0, 0, 0);
    send(OP_UPDATE, 16'h0000, 8'd40, 0, 0);
    send(OP_SELECT, 16'h0000, 8'd0, 0, 0);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      reg_write(3'd0, (ph == 5) ? 7'($urandom_range(0, 127)) : hl[ph]);
      reg_write(3'd4, (ph == 5) ? 7'($urandom_range(0, 127)) : ml[ph]);
      if (ph == 2) park_rx = 1;
      for (int k = 0; k < 188; k++) random_item((ph == 1) ? 55 : 25);
      drain();
    end

    $display("%0d requests, %0d results, %0d selects served, %0d table-full rejects",
             sent, sb.replies, sb.picks, sb.fulls);
    $display("limit settings covered zero, max, inverted and random values");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
